### rtl/telnet_ansi_line_editor_defines.svh
// Assertion macros used by the line editor checker
`ifndef TELNET_ANSI_LINE_EDITOR_DEFINES_SVH
`define TELNET_ANSI_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define TALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define TALE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tale_pkg.sv
// Shared types and constants of the telnet line editor
package tale_pkg;

  // Result event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_APPEND = 2'd1;
  localparam logic [1:0] EV_ERASE  = 2'd2;
  localparam logic [1:0] EV_LINE   = 2'd3;

  // Byte values
  localparam logic [7:0] BYTE_BS    = 8'd8;
  localparam logic [7:0] BYTE_LF    = 8'd10;
  localparam logic [7:0] BYTE_CR    = 8'd13;
  localparam logic [7:0] BYTE_ESC   = 8'd27;
  localparam logic [7:0] BYTE_SPACE = 8'd32;
  localparam logic [7:0] BYTE_SLASH = 8'd47;
  localparam logic [7:0] BYTE_ZERO  = 8'd48;
  localparam logic [7:0] BYTE_QMARK = 8'd63;
  localparam logic [7:0] BYTE_AT    = 8'd64;
  localparam logic [7:0] BYTE_LBRK  = 8'h5b;
  localparam logic [7:0] BYTE_TILDE = 8'h7e;
  localparam logic [7:0] BYTE_DEL   = 8'h7f;
  localparam logic [7:0] BYTE_SE    = 8'd240;
  localparam logic [7:0] BYTE_SB    = 8'd250;
  localparam logic [7:0] BYTE_WILL  = 8'd251;
  localparam logic [7:0] BYTE_DONT  = 8'd254;
  localparam logic [7:0] BYTE_IAC   = 8'd255;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_DASH  = 7'h2d;
  localparam logic [6:0] CHAR_TILDE = 7'h7e;

  // Command handed from the parser to the line buffer
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_EOL   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [6:0] ch;
  } cmd_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Line end just seen, for CRLF / LFCR pairing
  typedef enum logic [1:0] {
    END_NONE = 2'd0,
    END_CR   = 2'd1,
    END_LF   = 2'd2
  } line_end_t;

  // Parser modes
  typedef enum logic [9:0] {
    M_NORMAL    = 10'b00_0000_0001,
    M_ESC       = 10'b00_0000_0010,
    M_CSI_PARAM = 10'b00_0000_0100,
    M_CSI_INTER = 10'b00_0000_1000,
    M_ESC_INTER = 10'b00_0001_0000,
    M_IAC       = 10'b00_0010_0000,
    M_IAC_OPT   = 10'b00_0100_0000,
    M_SB_OPT    = 10'b00_1000_0000,
    M_SB_BODY   = 10'b01_0000_0000,
    M_SB_IAC    = 10'b10_0000_0000
  } parse_mode_t;

  // Line buffer sequencer states
  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_RD   = 4'b0010,
    B_CHK  = 4'b0100,
    B_OUT  = 4'b1000
  } back_state_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

### rtl/tale_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module tale_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tale_fifo.sv
// Two-entry command queue between the parser and the line buffer
module tale_fifo
  import tale_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // Pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  assign head_cmd   = slot_r[rp_r];
  assign stat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### rtl/tale_front.sv
// Byte parser: strips VT escapes and telnet commands, classifies the rest
module tale_front
  import tale_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  q_stat_t    q_stat,
  output logic       q_push,
  output cmd_t       q_cmd
);

  parse_mode_t mode_r, mode_nxt;
  line_end_t   end_r, end_nxt;

  parse_mode_t plain_mode;
  line_end_t   plain_end;
  cmd_t        plain_cmd;
  logic        again;
  logic [7:0]  b;
  parse_mode_t mode_fin;

  assign b         = in_tdata;
  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  // Ordinary byte handling
  always_comb begin
    plain_mode     = M_NORMAL;
    plain_end      = END_NONE;
    plain_cmd.kind = CMD_NOP;
    plain_cmd.ch   = '0;
    if (b == BYTE_ESC) begin
      plain_mode = M_ESC;
    end else if (b == BYTE_IAC) begin
      plain_mode = M_IAC;
    end else if (b == BYTE_CR || b == BYTE_LF) begin
      // second half of a CRLF or LFCR pair is swallowed
      if (!((end_r == END_CR && b == BYTE_LF) || (end_r == END_LF && b == BYTE_CR))) begin
        plain_cmd.kind = CMD_EOL;
        plain_end      = (b == BYTE_CR) ? END_CR : END_LF;
      end
    end else if (b == BYTE_BS || b == BYTE_DEL) begin
      plain_cmd.kind = CMD_ERASE;
    end else if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
      plain_cmd.kind = CMD_PUT;
      plain_cmd.ch   = (b == BYTE_TILDE) ? CHAR_DASH : b[6:0];
    end
  end

  // Sequence tracking
  always_comb begin
    mode_nxt = mode_r;
    again    = 1'b0;
    case (mode_r)
      M_NORMAL: begin
        again = 1'b1;
      end
      M_ESC: begin
        if (b == BYTE_LBRK) begin
          mode_nxt = M_CSI_PARAM;
        end else if (b >= BYTE_SPACE && b <= BYTE_SLASH) begin
          mode_nxt = M_ESC_INTER;
        end else begin
          mode_nxt = M_NORMAL;
          again    = !(b >= BYTE_ZERO && b <= BYTE_TILDE);
        end
      end
      M_ESC_INTER: begin
        if (!(b >= BYTE_SPACE && b <= BYTE_SLASH)) begin
          mode_nxt = M_NORMAL;
          again    = !(b >= BYTE_ZERO && b <= BYTE_TILDE);
        end
      end
      M_CSI_PARAM: begin
        if (b >= BYTE_SPACE && b <= BYTE_SLASH) begin
          mode_nxt = M_CSI_INTER;
        end else if (!(b >= BYTE_ZERO && b <= BYTE_QMARK)) begin
          mode_nxt = M_NORMAL;
          again    = !(b >= BYTE_AT && b <= BYTE_TILDE);
        end
      end
      M_CSI_INTER: begin
        if (!(b >= BYTE_SPACE && b <= BYTE_SLASH)) begin
          mode_nxt = M_NORMAL;
          again    = !(b >= BYTE_AT && b <= BYTE_TILDE);
        end
      end
      M_IAC: begin
        if (b == BYTE_SB) begin
          mode_nxt = M_SB_OPT;
        end else if (b >= BYTE_WILL && b <= BYTE_DONT) begin
          mode_nxt = M_IAC_OPT;
        end else begin
          mode_nxt = M_NORMAL;
          again    = (b < BYTE_SE);
        end
      end
      M_IAC_OPT: begin
        mode_nxt = M_NORMAL;
      end
      M_SB_OPT: begin
        mode_nxt = M_SB_BODY;
      end
      M_SB_BODY: begin
        if (b == BYTE_IAC) begin
          mode_nxt = M_SB_IAC;
        end
      end
      M_SB_IAC: begin
        mode_nxt = (b == BYTE_SE) ? M_NORMAL : M_SB_BODY;
      end
      default: begin
        mode_nxt = M_NORMAL;
        again    = 1'b1;
      end
    endcase
  end

  // Merge: a byte that falls out of a sequence is handled as plain input
  always_comb begin
    mode_fin = again ? plain_mode : mode_nxt;
  end

  always_comb begin
    if (again) begin
      end_nxt = plain_end;
      q_cmd   = plain_cmd;
    end else begin
      end_nxt = END_NONE;
      q_cmd   = '{kind: CMD_NOP, ch: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      end_r  <= END_NONE;
    end else if (q_push) begin
      mode_r <= mode_fin;
      end_r  <= end_nxt;
    end
  end

endmodule

### rtl/tale_back.sv
// Line buffer: applies commands, trims trailing spaces, drives the result register
module tale_back
  import tale_pkg::*;
#(
  parameter int LINE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int LW = $clog2(LINE_DEPTH);
  localparam logic [LW-1:0] FILL_MAX = LW'(LINE_DEPTH - 1);

  back_state_t   state_r, state_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] trim_r, trim_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    ev_r, ev_nxt;
  logic [6:0]    ch_r, ch_nxt;
  logic [7:0]    len_r, len_nxt;
  logic          ovf_r, ovf_nxt;

  logic          out_free;
  logic          load;
  logic [LW-1:0] ld_len;
  logic [LW+7:0] len_ext;

  logic          ram_we;
  logic          ram_re;
  logic [LW-1:0] ram_raddr;
  logic [6:0]    ram_rdata;

  assign out_free  = !out_valid_r || out_tready;
  assign ram_raddr = trim_r - 1'b1;
  assign len_ext   = {8'd0, ld_len};

  tale_ram #(
    .WIDTH (7),
    .DEPTH (LINE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (q_cmd.ch),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Command sequencer
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    trim_nxt  = trim_r;
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    load      = 1'b0;
    ev_nxt    = EV_NONE;
    ch_nxt    = '0;
    ovf_nxt   = 1'b0;
    ld_len    = fill_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            CMD_PUT: begin
              load = 1'b1;
              if (fill_r < FILL_MAX) begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + 1'b1;
                ld_len   = fill_r + 1'b1;
                ev_nxt   = EV_APPEND;
                ch_nxt   = q_cmd.ch;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_ERASE: begin
              load = 1'b1;
              if (fill_r != '0) begin
                fill_nxt = fill_r - 1'b1;
                ld_len   = fill_r - 1'b1;
                ev_nxt   = EV_ERASE;
              end
            end
            CMD_EOL: begin
              if (fill_r == '0) begin
                load   = 1'b1;
                ev_nxt = EV_LINE;
              end else begin
                trim_nxt  = fill_r;
                state_nxt = B_RD;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      B_RD: begin
        // fetch the last kept character
        ram_re    = 1'b1;
        state_nxt = B_CHK;
      end
      B_CHK: begin
        if (ram_rdata == CHAR_SPACE) begin
          trim_nxt  = trim_r - 1'b1;
          state_nxt = (trim_r == LW'(1)) ? B_OUT : B_RD;
        end else begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        ld_len = trim_r;
        if (out_free) begin
          load      = 1'b1;
          ev_nxt    = EV_LINE;
          fill_nxt  = '0;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    len_nxt       = len_ext[7:0];
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      fill_r      <= '0;
      trim_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      trim_r      <= trim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r  <= ev_nxt;
      ch_r  <= ch_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ev_r;
  assign out_tdata  = {ovf_r, len_r, ch_r};

endmodule

### rtl/telnet_ansi_line_editor.sv
// Top level of the telnet line editor
//
// Takes one received terminal byte per input transaction and returns exactly
// one result transaction per byte. A parser strips VT escapes and telnet IAC
// commands and classifies each byte; a two-entry queue hands the command to
// the line buffer, which holds up to LINE_DEPTH-1 characters in a RAM. A byte
// can be accepted every cycle while the queue has room; append, erase and
// ignored bytes are handled in the idle state. A line end walks back over
// the stored line one character at a time to trim trailing spaces, reading
// each character in B_RD and checking it in B_CHK, then hands the trimmed
// length out in B_OUT. No clearing pass is needed after reset.
module telnet_ansi_line_editor
  import tale_pkg::*;
#(
  parameter int LINE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] out_char, [14:7] line_length, [15] overflow
  output logic [1:0]  out_tuser   // [1:0] event_res
);

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    push_cmd;
  cmd_t    head_cmd;

  tale_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tale_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  tale_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/tale_checker.sv
// Port-level checks for the telnet line editor, bound to the top level
`include "telnet_ansi_line_editor_defines.svh"

module tale_checker
  import tale_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds
  `TALE_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A dropped character never comes with an event
  `TALE_ASSERT_IMP(a_ovf_no_event, out_tvalid && out_tdata[15], out_tuser == EV_NONE, "overflow with an event")

  // The character field is zero unless a character was appended
  `TALE_ASSERT_IMP(a_char_zero, out_tvalid && out_tuser != EV_APPEND, out_tdata[6:0] == 7'd0, "stray character")

  // Appended characters are printable and never a tilde
  `TALE_ASSERT_IMP(a_char_print, out_tvalid && out_tuser == EV_APPEND, out_tdata[6:0] >= CHAR_SPACE && out_tdata[6:0] < CHAR_TILDE, "bad appended character")

endmodule

bind telnet_ansi_line_editor tale_checker u_tale_checker (.*);

### verif/tb.sv
// Self-checking testbench for the telnet line editor: random byte streams, scoreboard
`timescale 1ns / 1ps

module tb;
  import tale_pkg::*;

  localparam int LINE_DEPTH  = 256;
  localparam int CYCLE_LIMIT = 300000;
  // worst line end: trimming walks back over up to LINE_DEPTH - 1 characters
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [1:0] ev;
    logic [6:0] ch;
    logic [7:0] len;
    logic       ovf;
  } edit_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [7:0] in_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [6:0] out_char, [14:7] line_length, [15] overflow
  logic [1:0]  out_tuser;          // [1:0] event_res

  // editor state mirrored by the predictor
  parse_mode_t ed_mode;
  line_end_t   last_end;
  logic [6:0]  line_mem [LINE_DEPTH];
  int unsigned line_fill;

  logic [7:0]   rx_bytes[$];        // bytes still to send
  edit_result_t pending_results[$]; // predicted results not yet seen
  edit_result_t want;

  logic byte_taken = 1'b0;
  logic result_taken = 1'b0;
  bit   send_calm = 1'b0;
  bit   recv_calm = 1'b0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   hold_left = 0;
  bit   hold_used = 1'b0;
  int   n_results = 0;
  int   errors = 0;
  int   cycle_cnt = 0;

  telnet_ansi_line_editor #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
  end

  // Predict the result of one byte and advance the mirrored state
  function automatic edit_result_t edit_byte(input logic [7:0] b);
    edit_result_t r;
    line_end_t    pend;
    bit           plain;
    int           n;
    pend     = last_end;
    last_end = END_NONE;
    r        = '{ev: EV_NONE, ch: 7'd0, len: line_fill[7:0], ovf: 1'b0};
    plain    = 1'b0;
    case (ed_mode)
      M_ESC: begin
        if (b == BYTE_LBRK) ed_mode = M_CSI_PARAM;
        else if (b >= BYTE_SPACE && b <= BYTE_SLASH) ed_mode = M_ESC_INTER;
        else if (b >= BYTE_ZERO && b <= BYTE_TILDE) ed_mode = M_NORMAL;
        else begin
          ed_mode = M_NORMAL;
          plain   = 1'b1;
        end
      end
      M_ESC_INTER: begin
        if (!(b >= BYTE_SPACE && b <= BYTE_SLASH)) begin
          ed_mode = M_NORMAL;
          plain   = !(b >= BYTE_ZERO && b <= BYTE_TILDE);
        end
      end
      M_CSI_PARAM: begin
        if (b >= BYTE_SPACE && b <= BYTE_SLASH) ed_mode = M_CSI_INTER;
        else if (!(b >= BYTE_ZERO && b <= BYTE_QMARK)) begin
          ed_mode = M_NORMAL;
          plain   = !(b >= BYTE_AT && b <= BYTE_TILDE);
        end
      end
      M_CSI_INTER: begin
        if (!(b >= BYTE_SPACE && b <= BYTE_SLASH)) begin
          ed_mode = M_NORMAL;
          plain   = !(b >= BYTE_AT && b <= BYTE_TILDE);
        end
      end
      M_IAC: begin
        if (b == BYTE_SB) ed_mode = M_SB_OPT;
        else if (b >= BYTE_WILL && b <= BYTE_DONT) ed_mode = M_IAC_OPT;
        else if (b >= BYTE_SE) ed_mode = M_NORMAL;
        else begin
          ed_mode = M_NORMAL;
          plain   = 1'b1;
        end
      end
      M_IAC_OPT: ed_mode = M_NORMAL;
      M_SB_OPT:  ed_mode = M_SB_BODY;
      M_SB_BODY: begin
        if (b == BYTE_IAC) ed_mode = M_SB_IAC;
      end
      M_SB_IAC:  ed_mode = (b == BYTE_SE) ? M_NORMAL : M_SB_BODY;
      default: begin
        ed_mode = M_NORMAL;
        plain   = 1'b1;
      end
    endcase

    if (plain) begin
      if (b == BYTE_ESC) begin
        ed_mode = M_ESC;
      end else if (b == BYTE_IAC) begin
        ed_mode = M_IAC;
      end else if (b == BYTE_CR || b == BYTE_LF) begin
        // second half of a CRLF / LFCR pair is swallowed
        if (!((pend == END_CR && b == BYTE_LF) || (pend == END_LF && b == BYTE_CR))) begin
          n = line_fill;
          while (n > 0 && line_mem[n-1] == CHAR_SPACE) n--;
          r.ev      = EV_LINE;
          r.len     = n[7:0];
          line_fill = 0;
          last_end  = (b == BYTE_CR) ? END_CR : END_LF;
        end
      end else if (b == BYTE_BS || b == BYTE_DEL) begin
        if (line_fill > 0) begin
          line_fill--;
          r.ev = EV_ERASE;
        end
        r.len = line_fill[7:0];
      end else if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
        if (line_fill < LINE_DEPTH - 1) begin
          line_mem[line_fill] = (b == BYTE_TILDE) ? CHAR_DASH : b[6:0];
          r.ev = EV_APPEND;
          r.ch = line_mem[line_fill];
          line_fill++;
        end else begin
          r.ovf = 1'b1;
        end
        r.len = line_fill[7:0];
      end
    end
    return r;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic logic [7:0] text_byte();
    return ($urandom_range(0, 3) == 0) ? BYTE_SPACE : 8'($urandom_range(32, 126));
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Input driver: presents the next byte once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || byte_taken)) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
        in_tvalid <= 1'b0;
      end else if (rx_bytes.size() > 0) begin
        in_tdata  <= rx_bytes.pop_front();
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_calm <= !send_calm;
        send_wait <= draw_wait(send_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off to back up the block
  always @(negedge clk) begin : recv_proc
    int gap;
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_used && n_results >= 120) begin
        hold_used  <= 1'b1;
        hold_left  <= 200;
        out_tready <= 1'b0;
      end else if (result_taken) begin
        if ($urandom_range(0, 31) == 0) recv_calm <= !recv_calm;
        gap = draw_wait(recv_calm);
        recv_wait  <= (gap > 0) ? gap - 1 : 0;
        out_tready <= (gap == 0);
      end else if (recv_wait > 0) begin
        recv_wait  <= recv_wait - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each byte transaction, check on each result transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      byte_taken   <= 1'b0;
      result_taken <= 1'b0;
      ed_mode      <= M_NORMAL;
      last_end     <= END_NONE;
      line_fill    <= 0;
    end else begin
      byte_taken   <= in_tvalid && in_tready;
      result_taken <= out_tvalid && out_tready;
      if (in_tvalid && in_tready)
        pending_results.push_back(edit_byte(in_tdata));
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected result, expected none, actual %h/%h",
                     $time, out_tuser, out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("event_res", want.ev, out_tuser);
          check_field("out_char", want.ch, out_tdata[6:0]);
          check_field("line_length", want.len, out_tdata[14:7]);
          check_field("overflow", want.ovf, out_tdata[15]);
        end
      end
    end
  end

  // Run time limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of test
  initial begin
    int          seg;
    int          n;
    int          k;
    logic [7:0]  c;
    bit          long_done;
    long_done = 1'b0;

    // directed: erase on empty, printable extremes, escapes, telnet commands, line ends
    rx_bytes = '{BYTE_BS, BYTE_SPACE, 8'h41, BYTE_TILDE, BYTE_DEL,
                 BYTE_ESC, BYTE_LBRK, 8'h31, BYTE_SPACE, 8'h71,
                 BYTE_ESC, 8'h28, 8'h42, BYTE_ESC, BYTE_CR, BYTE_LF,
                 BYTE_IAC, BYTE_WILL, 8'd1,
                 BYTE_IAC, BYTE_SB, 8'd24, BYTE_IAC, BYTE_IAC, BYTE_IAC, 8'd0,
                 BYTE_IAC, BYTE_SE,
                 BYTE_IAC, 8'h78, BYTE_IAC, BYTE_IAC, 8'd200, 8'd0, BYTE_LF, BYTE_CR};

    // random segments, mostly well-formed sequences
    while (rx_bytes.size() < 990) begin
      if (!long_done && rx_bytes.size() > 250) begin
        // fill up to or past the line capacity, ending in a long run of spaces
        long_done = 1'b1;
        n = $urandom_range(190, 200);
        for (k = 0; k < n; k++) rx_bytes.push_back(8'($urandom_range(33, 126)));
        for (k = 0; k < 65; k++) rx_bytes.push_back(BYTE_SPACE);
        rx_bytes.push_back(BYTE_CR);
      end
      seg = $urandom_range(0, 99);
      if (seg < 40) begin
        n = $urandom_range(1, 10);
        for (k = 0; k < n; k++) rx_bytes.push_back(text_byte());
      end else if (seg < 48) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
          rx_bytes.push_back($urandom_range(0, 1) ? BYTE_BS : BYTE_DEL);
      end else if (seg < 58) begin
        c = $urandom_range(0, 1) ? BYTE_CR : BYTE_LF;
        rx_bytes.push_back(c);
        if ($urandom_range(0, 1))
          rx_bytes.push_back($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
      end else if (seg < 66) begin
        rx_bytes.push_back(BYTE_ESC);
        rx_bytes.push_back(BYTE_LBRK);
        n = $urandom_range(0, 4);
        for (k = 0; k < n; k++) rx_bytes.push_back(8'($urandom_range(48, 63)));
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) rx_bytes.push_back(8'($urandom_range(32, 47)));
        rx_bytes.push_back(8'($urandom_range(64, 126)));
      end else if (seg < 70) begin
        rx_bytes.push_back(BYTE_ESC);
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) rx_bytes.push_back(8'($urandom_range(32, 47)));
        rx_bytes.push_back(8'($urandom_range(48, 126)));
      end else if (seg < 75) begin
        // escape cut short by a byte of the wrong class
        rx_bytes.push_back(BYTE_ESC);
        if ($urandom_range(0, 1)) begin
          rx_bytes.push_back(BYTE_LBRK);
          n = $urandom_range(0, 2);
          for (k = 0; k < n; k++) rx_bytes.push_back(8'($urandom_range(48, 63)));
        end
        rx_bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                : 8'($urandom_range(127, 255)));
      end else if (seg < 81) begin
        c = 8'($urandom_range(240, 253));
        if (c >= BYTE_SB) c++;
        rx_bytes.push_back(BYTE_IAC);
        rx_bytes.push_back(c);
        if (c >= BYTE_WILL) rx_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (seg < 86) begin
        rx_bytes.push_back(BYTE_IAC);
        rx_bytes.push_back(BYTE_SB);
        rx_bytes.push_back(8'($urandom_range(0, 255)));
        n = $urandom_range(0, 6);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 7))
            0: begin
              rx_bytes.push_back(BYTE_IAC);
              rx_bytes.push_back(BYTE_IAC);
            end
            1: begin
              rx_bytes.push_back(BYTE_IAC);
              rx_bytes.push_back(8'($urandom_range(0, 239)));
            end
            default: rx_bytes.push_back(8'($urandom_range(0, 254)));
          endcase
        end
        rx_bytes.push_back(BYTE_IAC);
        rx_bytes.push_back(BYTE_SE);
      end else if (seg < 89) begin
        rx_bytes.push_back(BYTE_IAC);
        rx_bytes.push_back(8'($urandom_range(0, 239)));
      end else begin
        rx_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end

    // wait for all bytes to go out and all results to come back
    @(posedge rst_n);
    while (rx_bytes.size() > 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

### telnet_ansi_line_editor.f
+incdir+rtl
rtl/tale_pkg.sv
rtl/tale_ram.sv
rtl/tale_fifo.sv
rtl/tale_front.sv
rtl/tale_back.sv
rtl/telnet_ansi_line_editor.sv
rtl/tale_checker.sv
verif/tb.sv
